### rtl/audio_fifo_underrun_recovery_macros.svh
// Assertion helpers for the checks in the top-level module of this block.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef AUDIO_FIFO_UNDERRUN_RECOVERY_MACROS_SVH
`define AUDIO_FIFO_UNDERRUN_RECOVERY_MACROS_SVH

// Same-cycle implication.
`define AFUR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("afur: same-cycle check failed");

// Next-cycle implication.
`define AFUR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("afur: next-cycle check failed");

`endif

### rtl/afur_pkg.sv
package afur_pkg;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned BCOUNT_W   = 16;
  localparam int unsigned POP_W      = 7;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned LEVEL_W    = 13;
  localparam int unsigned STAT_W     = 32;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  // Action codes on the input channel
  localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_MARGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE    = 2'd1;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR_STATS,
    OP_STATUS
  } op_e;

  // One classified transaction waiting for the back end
  typedef struct packed {
    op_e                 op;
    logic                bstart;
    logic [BCOUNT_W-1:0] bcount;
    logic [POP_W-1:0]    n;
  } entry_t;

  // Result metadata travelling alongside the RAM read data
  typedef struct packed {
    logic               use_ram;
    logic               last;
    logic               accepted;
    logic               silenced;
    logic [LEVEL_W-1:0] fill;
    logic [STAT_W-1:0]  underrun;
    logic [STAT_W-1:0]  overrun;
  } res_t;

  typedef struct packed {
    logic                 wr;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

### rtl/audio_fifo_underrun_recovery.sv
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+---------------------------------------------
// in       | sink      | in_valid / in_stall | action, push_sample, batch_start/count, pop_count
// out      | source    | out_valid/out_stall | sample_out, last, accepted, silenced, levels
// cfg      | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// Push, statistics clear and status items each give one result; a pop of zero words
// is dropped at the front. A pop of n words has a decision step, then streams one word
// a cycle unless the output stalls: RAM words via the registered read port, then silence.
// Asynchronous active-low reset clears pointers, levels and counters; RAM contents are
// undefined until written, so no clearing pass is needed.
// A two-entry queue decouples input from the back end; the RAM read stage and the output
// register absorb output stalls, and in_stall_o rises only when the queue is full.
`include "audio_fifo_underrun_recovery_macros.svh"

module audio_fifo_underrun_recovery #(
  parameter int unsigned FIFO_DEPTH  = 4096,
  parameter int unsigned MAX_POP     = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [afur_pkg::ACTION_W-1:0]      action_i,
  input  logic [afur_pkg::WORD_W-1:0]        push_sample_i,
  input  logic                               batch_start_i,
  input  logic [afur_pkg::BCOUNT_W-1:0]      batch_count_i,
  input  logic [afur_pkg::POP_W-1:0]         pop_count_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [afur_pkg::WORD_W-1:0]        sample_out_o,
  output logic                               last_o,
  output logic                               accepted_o,
  output logic                               silenced_o,
  output logic [afur_pkg::LEVEL_W-1:0]       fill_level_o,
  output logic [afur_pkg::STAT_W-1:0]        underrun_total_o,
  output logic [afur_pkg::STAT_W-1:0]        overrun_total_o,

  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [afur_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [afur_pkg::CFG_W-1:0]         cfg_data_i
);

  logic                     head_valid;
  afur_pkg::entry_t         head;
  logic [SAMPLE_BITS-1:0]   head_sample;
  logic                     deq;
  afur_pkg::cfg_wr_t        cfg_wr;
  logic                     out_ready;
  logic                     b_valid;
  afur_pkg::res_t           b_res;
  logic [SAMPLE_BITS-1:0]   b_data;
  afur_pkg::res_t           out_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr.wr   = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.idx  = cfg_index_i;
  assign cfg_wr.data = cfg_data_i;

  afur_front #(
    .MAX_POP     (MAX_POP),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .push_sample_i (push_sample_i),
    .batch_start_i (batch_start_i),
    .batch_count_i (batch_count_i),
    .pop_count_i   (pop_count_i),
    .deq_i         (deq),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .head_sample_o (head_sample)
  );

  afur_back #(
    .FIFO_DEPTH  (FIFO_DEPTH),
    .MAX_POP     (MAX_POP),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_wr),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .head_sample_i (head_sample),
    .deq_o         (deq),
    .out_ready_i   (out_ready),
    .b_valid_o     (b_valid),
    .b_res_o       (b_res),
    .b_data_o      (b_data)
  );

  afur_out #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .b_valid_i (b_valid),
    .b_res_i   (b_res),
    .b_data_i  (b_data),
    .ready_o   (out_ready),
    .stall_i   (out_stall_i),
    .valid_o   (out_valid_o),
    .res_o     (out_res),
    .sample_o  (sample_out_o)
  );

  assign last_o           = out_res.last;
  assign accepted_o       = out_res.accepted;
  assign silenced_o       = out_res.silenced;
  assign fill_level_o     = out_res.fill;
  assign underrun_total_o = out_res.underrun;
  assign overrun_total_o  = out_res.overrun;

  // A push result never carries a word or silence
  `AFUR_ASSERT_IMP(a_accept_excl, out_valid_o && accepted_o,
                   !silenced_o && (sample_out_o == '0))
  // Silence is always a zero word
  `AFUR_ASSERT_IMP(a_silence_zero, out_valid_o && silenced_o, sample_out_o == '0)
  // Words of one pop follow back to back once one is taken
  `AFUR_ASSERT_NXT(a_pop_streams, out_valid_o && !out_stall_i && !last_o, out_valid_o)

endmodule

### rtl/afur_ram.sv
module afur_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/afur_front.sv
module afur_front #(
  parameter int unsigned MAX_POP     = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [afur_pkg::ACTION_W-1:0]    action_i,
  input  logic [afur_pkg::WORD_W-1:0]      push_sample_i,
  input  logic                             batch_start_i,
  input  logic [afur_pkg::BCOUNT_W-1:0]    batch_count_i,
  input  logic [afur_pkg::POP_W-1:0]       pop_count_i,
  input  logic                             deq_i,
  output logic                             head_valid_o,
  output afur_pkg::entry_t                 head_o,
  output logic [SAMPLE_BITS-1:0]           head_sample_o
);

  afur_pkg::entry_t        entry_q  [2];
  logic [SAMPLE_BITS-1:0]  sample_q [2];
  logic                    wr_ptr_q, wr_ptr_d;
  logic                    rd_ptr_q, rd_ptr_d;
  logic [1:0]              cnt_q, cnt_d;

  afur_pkg::entry_t        cls;
  logic                    keep;
  logic                    enq;

  // Classify: saturate the pop length, drop empty pops
  always_comb begin
    cls        = '0;
    cls.bstart = batch_start_i;
    cls.bcount = batch_count_i;
    cls.n      = (pop_count_i > afur_pkg::POP_W'(MAX_POP)) ? afur_pkg::POP_W'(MAX_POP)
                                                          : pop_count_i;
    unique case (action_i)
      afur_pkg::ACT_PUSH:  cls.op = afur_pkg::OP_PUSH;
      afur_pkg::ACT_POP:   cls.op = afur_pkg::OP_POP;
      afur_pkg::ACT_CLEAR: cls.op = afur_pkg::OP_CLEAR_STATS;
      default:             cls.op = afur_pkg::OP_STATUS;
    endcase
    keep = !((cls.op == afur_pkg::OP_POP) && (cls.n == '0));
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign enq        = in_valid_i && !in_stall_o && keep;

  always_comb begin
    wr_ptr_d = enq   ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(enq) - 2'(deq_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      entry_q[wr_ptr_q]  <= cls;
      sample_q[wr_ptr_q] <= push_sample_i[SAMPLE_BITS-1:0];
    end
  end

  assign head_valid_o  = (cnt_q != 2'd0);
  assign head_o        = entry_q[rd_ptr_q];
  assign head_sample_o = sample_q[rd_ptr_q];

endmodule

### rtl/afur_back.sv
module afur_back #(
  parameter int unsigned FIFO_DEPTH  = 4096,
  parameter int unsigned MAX_POP     = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  afur_pkg::cfg_wr_t      cfg_i,
  input  logic                   head_valid_i,
  input  afur_pkg::entry_t       head_i,
  input  logic [SAMPLE_BITS-1:0] head_sample_i,
  output logic                   deq_o,
  input  logic                   out_ready_i,
  output logic                   b_valid_o,
  output afur_pkg::res_t         b_res_o,
  output logic [SAMPLE_BITS-1:0] b_data_o
);

  localparam int unsigned PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CMP_W   = (CNT_W > 16) ? CNT_W : 16;
  localparam int unsigned RW      = (CNT_W > 14) ? CNT_W : 14;
  localparam int unsigned NW      = (CNT_W > 7) ? CNT_W : 7;
  localparam int unsigned K_W     = $clog2(MAX_POP + 1);
  localparam int unsigned CAP_RST = (FIFO_DEPTH < 4096) ? FIFO_DEPTH : 4096;
  localparam int unsigned POP_W   = afur_pkg::POP_W;

  typedef enum logic {
    S_DISPATCH,
    S_STREAM
  } state_e;

  state_e                      state_q, state_d;
  logic [PTR_W-1:0]            rp_q, rp_d;
  logic [PTR_W-1:0]            wp_q, wp_d;
  logic [CNT_W-1:0]            fill_q, fill_d;
  logic                        exh_q, exh_d;
  logic [POP_W-1:0]            lp_q, lp_d;
  logic [afur_pkg::STAT_W-1:0] und_q, und_d;
  logic [afur_pkg::STAT_W-1:0] ovr_q, ovr_d;
  logic [CNT_W-1:0]            bwl_q, bwl_d;
  logic [afur_pkg::CFG_W-1:0]  margin_q, margin_d;
  logic [CNT_W-1:0]            cap_q, cap_d;
  logic [POP_W-1:0]            n_q, n_d;
  logic [POP_W-1:0]            avail_q, avail_d;
  logic [K_W-1:0]              k_q, k_d;
  logic                        b_valid_q, b_valid_d;
  afur_pkg::res_t              b_res_q, b_res_d;

  logic                        b_free;
  logic                        emit;
  afur_pkg::res_t              res;
  logic                        ram_we;
  logic                        ram_re;

  // Pop decision terms
  logic [POP_W-1:0]            lp_new;
  logic [RW-1:0]               recover;
  logic [RW-1:0]               recov_cap;
  logic                        silent;
  logic                        is_short;
  logic [POP_W-1:0]            avail_new;

  // Push terms
  logic [CNT_W-1:0]            free_sp;
  logic [CMP_W-1:0]            bc_x;
  logic [CNT_W-1:0]            writable;
  logic [CNT_W-1:0]            bwl_eff;
  logic                        store;
  logic                        overflow;

  // Config terms
  logic [CNT_W-1:0]            cap_new;

  logic                        last_word;
  logic                        real_word;

  assign b_free = !b_valid_q || out_ready_i;

  assign lp_new    = (head_i.n > lp_q) ? head_i.n : lp_q;
  assign recover   = RW'(margin_q) + RW'(lp_new);
  assign recov_cap = (recover > RW'(cap_q)) ? RW'(cap_q) : recover;
  assign silent    = exh_q && (RW'(fill_q) < recov_cap);
  assign is_short  = NW'(fill_q) < NW'(head_i.n);
  assign avail_new = is_short ? POP_W'(fill_q) : head_i.n;

  // Free space is taken at the first sample of a batch
  assign free_sp  = (fill_q < cap_q) ? (cap_q - fill_q) : '0;
  assign bc_x     = CMP_W'(head_i.bcount);
  assign writable = (bc_x < CMP_W'(free_sp)) ? CNT_W'(head_i.bcount) : free_sp;
  assign overflow = head_i.bstart && (CMP_W'(writable) < bc_x);
  assign bwl_eff  = head_i.bstart ? writable : bwl_q;
  assign store    = (bwl_eff != '0) && (fill_q < CNT_W'(FIFO_DEPTH));

  assign cap_new = (CMP_W'(cfg_i.data) > CMP_W'(FIFO_DEPTH)) ? CNT_W'(FIFO_DEPTH)
                                                             : CNT_W'(cfg_i.data);

  assign last_word = (POP_W'(k_q) + POP_W'(1)) == n_q;
  assign real_word = POP_W'(k_q) < avail_q;

  always_comb begin
    state_d  = state_q;
    rp_d     = rp_q;
    wp_d     = wp_q;
    fill_d   = fill_q;
    exh_d    = exh_q;
    lp_d     = lp_q;
    und_d    = und_q;
    ovr_d    = ovr_q;
    bwl_d    = bwl_q;
    margin_d = margin_q;
    cap_d    = cap_q;
    n_d      = n_q;
    avail_d  = avail_q;
    k_d      = k_q;
    deq_o    = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    emit     = 1'b0;
    res      = '0;

    unique case (state_q)
      S_DISPATCH: begin
        if (head_valid_i) begin
          unique case (head_i.op)
            afur_pkg::OP_PUSH: begin
              if (b_free) begin
                deq_o        = 1'b1;
                emit         = 1'b1;
                res.last     = 1'b1;
                res.accepted = store;
                if (overflow) begin
                  ovr_d = ovr_q + 1'b1;
                end
                bwl_d = bwl_eff;
                if (store) begin
                  ram_we = 1'b1;
                  wp_d   = (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
                  fill_d = fill_q + 1'b1;
                  bwl_d  = bwl_eff - 1'b1;
                end
              end
            end
            afur_pkg::OP_POP: begin
              // Decide once per request, then stream the words
              deq_o   = 1'b1;
              lp_d    = lp_new;
              n_d     = head_i.n;
              k_d     = '0;
              state_d = S_STREAM;
              if (silent) begin
                und_d   = und_q + 1'b1;
                avail_d = '0;
              end else begin
                exh_d   = is_short;
                avail_d = avail_new;
                if (is_short) begin
                  und_d = und_q + 1'b1;
                end
              end
            end
            afur_pkg::OP_CLEAR_STATS: begin
              if (b_free) begin
                deq_o    = 1'b1;
                emit     = 1'b1;
                res.last = 1'b1;
                und_d    = '0;
                ovr_d    = '0;
              end
            end
            default: begin
              if (b_free) begin
                deq_o    = 1'b1;
                emit     = 1'b1;
                res.last = 1'b1;
              end
            end
          endcase
        end
      end
      S_STREAM: begin
        if (b_free) begin
          emit     = 1'b1;
          res.last = last_word;
          k_d      = k_q + 1'b1;
          if (real_word) begin
            ram_re      = 1'b1;
            res.use_ram = 1'b1;
            rp_d        = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
            fill_d      = fill_q - 1'b1;
          end else begin
            res.silenced = 1'b1;
          end
          if (last_word) begin
            state_d = S_DISPATCH;
          end
        end
      end
      default: state_d = S_DISPATCH;
    endcase

    res.fill     = afur_pkg::LEVEL_W'(fill_d);
    res.underrun = und_d;
    res.overrun  = ovr_d;

    if (cfg_i.wr) begin
      unique case (cfg_i.idx)
        afur_pkg::CFG_RECOVER_MARGIN: margin_d = cfg_i.data;
        afur_pkg::CFG_BUFFER_SIZE:    cap_d    = cap_new;
        default: ;
      endcase
    end

    b_valid_d = b_valid_q;
    b_res_d   = b_res_q;
    if (b_free) begin
      b_valid_d = emit;
      b_res_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_DISPATCH;
      rp_q      <= '0;
      wp_q      <= '0;
      fill_q    <= '0;
      exh_q     <= 1'b0;
      lp_q      <= '0;
      und_q     <= '0;
      ovr_q     <= '0;
      bwl_q     <= '0;
      margin_q  <= '0;
      cap_q     <= CNT_W'(CAP_RST);
      n_q       <= '0;
      avail_q   <= '0;
      k_q       <= '0;
      b_valid_q <= 1'b0;
      b_res_q   <= '0;
    end else begin
      state_q   <= state_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      exh_q     <= exh_d;
      lp_q      <= lp_d;
      und_q     <= und_d;
      ovr_q     <= ovr_d;
      bwl_q     <= bwl_d;
      margin_q  <= margin_d;
      cap_q     <= cap_d;
      n_q       <= n_d;
      avail_q   <= avail_d;
      k_q       <= k_d;
      b_valid_q <= b_valid_d;
      b_res_q   <= b_res_d;
    end
  end

  afur_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (head_sample_i),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (b_data_o)
  );

  assign b_valid_o = b_valid_q;
  assign b_res_o   = b_res_q;

endmodule

### rtl/afur_out.sv
module afur_out #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              b_valid_i,
  input  afur_pkg::res_t                    b_res_i,
  input  logic [SAMPLE_BITS-1:0]            b_data_i,
  output logic                              ready_o,
  input  logic                              stall_i,
  output logic                              valid_o,
  output afur_pkg::res_t                    res_o,
  output logic [afur_pkg::WORD_W-1:0]       sample_o
);

  logic                          valid_q, valid_d;
  afur_pkg::res_t                res_q;
  logic [afur_pkg::WORD_W-1:0]   sample_q;
  logic                          load;

  assign ready_o = !valid_q || !stall_i;
  assign load    = b_valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = b_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Silence, push, clear and status results carry a zero word
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q    <= b_res_i;
      sample_q <= b_res_i.use_ram ? afur_pkg::WORD_W'(b_data_i) : '0;
    end
  end

  assign valid_o  = valid_q;
  assign res_o    = res_q;
  assign sample_o = sample_q;

endmodule

### tb/audio_fifo_underrun_recovery_test.sv
module audio_fifo_underrun_recovery_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_DEPTH = 4096;
  localparam int unsigned POP_LIMIT    = 64;
  localparam logic [afur_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [afur_pkg::ACTION_W-1:0] action;
    logic [afur_pkg::WORD_W-1:0]   sample;
    logic                          bstart;
    logic [afur_pkg::BCOUNT_W-1:0] bcount;
    logic [afur_pkg::POP_W-1:0]    pcount;
  } fifo_req_t;

  typedef struct packed {
    logic [afur_pkg::WORD_W-1:0]  word;
    logic                         last;
    logic                         accepted;
    logic                         silenced;
    logic [afur_pkg::LEVEL_W-1:0] fill;
    logic [afur_pkg::STAT_W-1:0]  underrun;
    logic [afur_pkg::STAT_W-1:0]  overrun;
  } fifo_word_t;

  class fifo_tracker;
    logic [afur_pkg::WORD_W-1:0] store [SAMPLE_DEPTH];
    int unsigned rd_ptr, wr_ptr, fill, batch_left, largest;
    int unsigned margin, bufsize;
    bit exhausted;
    logic [afur_pkg::STAT_W-1:0] underruns, overruns;
    fifo_word_t pending_words [$];
    int unsigned fail_count, results_seen, silent_seen;

    function new();
      rd_ptr = 0; wr_ptr = 0; fill = 0; batch_left = 0; largest = 0;
      margin = 0; bufsize = 4096; exhausted = 1'b0;
      underruns = '0; overruns = '0;
      fail_count = 0; results_seen = 0; silent_seen = 0;
    endfunction

    function void set_register(logic [afur_pkg::CFG_IDX_W-1:0] idx,
                               logic [afur_pkg::CFG_W-1:0] data);
      if (idx == afur_pkg::CFG_RECOVER_MARGIN) margin = 32'(data);
      else if (idx == afur_pkg::CFG_BUFFER_SIZE) bufsize = 32'(data);
    endfunction

    function int unsigned capacity();
      return (bufsize > SAMPLE_DEPTH) ? SAMPLE_DEPTH : bufsize;
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction

    function void add_word(logic [afur_pkg::WORD_W-1:0] w, bit lst, bit acc, bit sil);
      fifo_word_t r;
      r.word = w;
      r.last = lst;
      r.accepted = acc;
      r.silenced = sil;
      r.fill = afur_pkg::LEVEL_W'(fill);
      r.underrun = underruns;
      r.overrun = overruns;
      pending_words.push_back(r);
    endfunction

    // Work out every word that one accepted transaction produces.
    function void take_request(fifo_req_t rq);
      int unsigned n, cap, freesp, writable, recover, avail, bcnt;
      bit acc;
      bcnt = 32'(rq.bcount);
      n = 32'(rq.pcount);
      if (n > POP_LIMIT) n = POP_LIMIT;
      case (rq.action)
        afur_pkg::ACT_PUSH: begin
          acc = 1'b0;
          if (rq.bstart) begin
            cap = capacity();
            freesp = (fill < cap) ? cap - fill : 0;
            writable = (bcnt < freesp) ? bcnt : freesp;
            if (writable < bcnt) overruns++;
            batch_left = writable;
          end
          if (batch_left > 0 && fill < SAMPLE_DEPTH) begin
            store[wr_ptr] = rq.sample;
            wr_ptr = (wr_ptr + 1) % SAMPLE_DEPTH;
            fill++;
            batch_left--;
            acc = 1'b1;
          end
          add_word('0, 1'b1, acc, 1'b0);
        end
        afur_pkg::ACT_POP: begin
          if (n == 0) return;
          if (n > largest) largest = n;
          cap = capacity();
          recover = margin + largest;
          if (recover > cap) recover = cap;
          if (exhausted && fill < recover) begin
            // still below the recovery threshold: whole request is silence
            underruns++;
            for (int unsigned k = 0; k < n; k++) add_word('0, k == n - 1, 1'b0, 1'b1);
          end else begin
            exhausted = 1'b0;
            avail = (fill < n) ? fill : n;
            if (avail < n) begin
              exhausted = 1'b1;
              underruns++;
            end
            for (int unsigned k = 0; k < n; k++) begin
              if (k < avail) begin
                fill--;
                add_word(store[rd_ptr], k == n - 1, 1'b0, 1'b0);
                rd_ptr = (rd_ptr + 1) % SAMPLE_DEPTH;
              end else begin
                add_word('0, k == n - 1, 1'b0, 1'b1);
              end
            end
          end
        end
        afur_pkg::ACT_CLEAR: begin
          underruns = '0;
          overruns = '0;
          add_word('0, 1'b1, 1'b0, 1'b0);
        end
        default: add_word('0, 1'b1, 1'b0, 1'b0);
      endcase
    endfunction

    task report_mismatch(string what, logic [afur_pkg::WORD_W-1:0] got,
                         logic [afur_pkg::WORD_W-1:0] want);
      fail_count++;
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task check_output(fifo_word_t got);
      fifo_word_t want;
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing outstanding", got.word, '0);
        return;
      end
      want = pending_words.pop_front();
      results_seen++;
      if (got.silenced) silent_seen++;
      if (got.word !== want.word) report_mismatch("sample_out", got.word, want.word);
      if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
      if (got.accepted !== want.accepted)
        report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
      if (got.silenced !== want.silenced)
        report_mismatch("silenced", 32'(got.silenced), 32'(want.silenced));
      if (got.fill !== want.fill)
        report_mismatch("fill_level", 32'(got.fill), 32'(want.fill));
      if (got.underrun !== want.underrun)
        report_mismatch("underrun_total", got.underrun, want.underrun);
      if (got.overrun !== want.overrun)
        report_mismatch("overrun_total", got.overrun, want.overrun);
    endtask
  endclass

  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 200;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic [afur_pkg::ACTION_W-1:0]  action_i      = '0;
  logic [afur_pkg::WORD_W-1:0]    push_sample_i = '0;
  logic                           batch_start_i = 1'b0;
  logic [afur_pkg::BCOUNT_W-1:0]  batch_count_i = '0;
  logic [afur_pkg::POP_W-1:0]     pop_count_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic [afur_pkg::WORD_W-1:0]    sample_out_o;
  logic                           last_o;
  logic                           accepted_o;
  logic                           silenced_o;
  logic [afur_pkg::LEVEL_W-1:0]   fill_level_o;
  logic [afur_pkg::STAT_W-1:0]    underrun_total_o;
  logic [afur_pkg::STAT_W-1:0]    overrun_total_o;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [afur_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [afur_pkg::CFG_W-1:0]     cfg_data_i    = '0;

  fifo_tracker sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;
  int unsigned items_sent    = 0;
  int unsigned quiet_cycles  = 0;

  audio_fifo_underrun_recovery u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .push_sample_i    (push_sample_i),
    .batch_start_i    (batch_start_i),
    .batch_count_i    (batch_count_i),
    .pop_count_i      (pop_count_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_out_o     (sample_out_o),
    .last_o           (last_o),
    .accepted_o       (accepted_o),
    .silenced_o       (silenced_o),
    .fill_level_o     (fill_level_o),
    .underrun_total_o (underrun_total_o),
    .overrun_total_o  (overrun_total_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sink side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    fifo_word_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.word = sample_out_o;
      got.last = last_o;
      got.accepted = accepted_o;
      got.silenced = silenced_o;
      got.fill = fill_level_o;
      got.underrun = underrun_total_o;
      got.overrun = overrun_total_o;
      sb.check_output(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d words outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [afur_pkg::ACTION_W-1:0] act,
                           input logic [afur_pkg::WORD_W-1:0] smp,
                           input logic bst, input logic [afur_pkg::BCOUNT_W-1:0] bcnt,
                           input logic [afur_pkg::POP_W-1:0] pcnt);
    fifo_req_t rq;
    rq.action = act;
    rq.sample = smp;
    rq.bstart = bst;
    rq.bcount = bcnt;
    rq.pcount = pcnt;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    action_i      <= act;
    push_sample_i <= smp;
    batch_start_i <= bst;
    batch_count_i <= bcnt;
    pop_count_i   <= pcnt;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_request(rq);
    if (!(act == afur_pkg::ACT_POP && pcnt == 0)) items_sent++;
  endtask

  // Drop valid and wait until every outstanding word has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [afur_pkg::CFG_IDX_W-1:0] idx,
                           input logic [afur_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [afur_pkg::CFG_W-1:0] margin,
                           input logic [afur_pkg::CFG_W-1:0] size);
    settle();
    write_reg(afur_pkg::CFG_RECOVER_MARGIN, margin);
    write_reg(afur_pkg::CFG_BUFFER_SIZE, size);
  endtask

  task automatic random_batch();
    int unsigned r, len, n_send;
    r = $urandom_range(99);
    if (r < 75) len = $urandom_range(1, 10);
    else if (r < 85) len = $urandom_range(11, 30);
    else if (r < 93) len = 65535;
    else len = $urandom_range(0, 65535);
    n_send = (len <= 30) ? len : $urandom_range(1, 6);
    if (n_send == 0) n_send = 1;
    // cut a few batches short, overrun a few with trailing pushes
    r = $urandom_range(99);
    if (r < 10 && n_send > 1) n_send--;
    else if (r < 20) n_send += $urandom_range(1, 2);
    for (int unsigned k = 0; k < n_send; k++)
      send_item(afur_pkg::ACT_PUSH, $urandom(), k == 0,
                (k == 0) ? afur_pkg::BCOUNT_W'(len)
                         : afur_pkg::BCOUNT_W'($urandom_range(0, 65535)),
                afur_pkg::POP_W'($urandom_range(0, 127)));
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned first, r, pc;
    first = items_sent;
    while (items_sent - first < count) begin
      r = $urandom_range(99);
      if (r < 45) begin
        random_batch();
      end else if (r < 50) begin
        send_item(afur_pkg::ACT_PUSH, $urandom(), 1'b0,
                  afur_pkg::BCOUNT_W'($urandom_range(0, 65535)),
                  afur_pkg::POP_W'($urandom_range(0, 127)));
      end else if (r < 82) begin
        r = $urandom_range(99);
        if (r < 65) pc = $urandom_range(1, 16);
        else if (r < 80) pc = $urandom_range(17, 64);
        else if (r < 90) pc = $urandom_range(65, 127);
        else pc = 0;
        send_item(afur_pkg::ACT_POP, $urandom(), 1'($urandom_range(1)),
                  afur_pkg::BCOUNT_W'($urandom_range(0, 65535)), afur_pkg::POP_W'(pc));
      end else if (r < 92) begin
        send_item(afur_pkg::ACT_CLEAR, $urandom(), 1'($urandom_range(1)),
                  afur_pkg::BCOUNT_W'($urandom()), '0);
      end else begin
        send_item(ACT_UNUSED, $urandom(), 1'($urandom_range(1)),
                  afur_pkg::BCOUNT_W'($urandom()),
                  afur_pkg::POP_W'($urandom_range(0, 127)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: default capacity, no idling.
    configure(13'd0, 13'd4096);
    send_item(ACT_UNUSED, '0, 1'b0, '0, '0);
    send_item(afur_pkg::ACT_POP, '0, 1'b0, '0, 7'd1);
    send_item(afur_pkg::ACT_PUSH, 32'hFFFF_FFFF, 1'b1, 16'd3, '0);
    send_item(afur_pkg::ACT_PUSH, 32'h0000_0000, 1'b0, '0, '0);
    send_item(afur_pkg::ACT_PUSH, 32'hA5A5_5A5A, 1'b0, '0, '0);
    send_item(afur_pkg::ACT_PUSH, 32'h1234_5678, 1'b0, '0, '0);
    send_item(afur_pkg::ACT_POP, '0, 1'b0, '0, 7'd0);
    send_item(afur_pkg::ACT_POP, '0, 1'b0, '0, 7'd2);
    send_item(afur_pkg::ACT_POP, '0, 1'b0, '0, 7'd127);
    send_item(afur_pkg::ACT_PUSH, 32'h0F0F_0F0F, 1'b1, 16'd0, '0);
    send_item(afur_pkg::ACT_PUSH, 32'hF0F0_F0F0, 1'b0, '0, '0);
    send_item(afur_pkg::ACT_PUSH, 32'h8000_0001, 1'b1, 16'hFFFF, 7'h7F);
    send_item(afur_pkg::ACT_POP, '0, 1'b0, '0, 7'd64);
    send_item(afur_pkg::ACT_CLEAR, '0, 1'b0, '0, '0);
    send_item(afur_pkg::ACT_PUSH, 32'h7FFF_FFFE, 1'b1, 16'd2, '0);
    send_item(afur_pkg::ACT_PUSH, 32'h5555_AAAA, 1'b0, '0, '0);
    send_item(afur_pkg::ACT_POP, '0, 1'b0, '0, 7'd3);
    random_items(40);

    configure(13'd8, 13'd24);
    send_idle_pct = 49;
    random_items(45);
    // leave the buffer holding more than the next, smaller capacity
    for (int k = 0; k < 4; k++)
      send_item(afur_pkg::ACT_PUSH, $urandom(), k == 0, 16'd4, '0);

    configure(13'd3, 13'd1);
    send_idle_pct = 0;
    stall_pct = 49;
    random_items(15);
    hold_request = HOLD_CYCLES;
    random_items(30);

    configure(13'h1FFF, 13'h1FFF);
    send_idle_pct = 22;
    stall_pct = 22;
    random_items(50);

    settle();
    $display("Covered %0d requests over four margin/capacity settings with idle and stall mixes.",
             items_sent);
    $display("Checked %0d output words, %0d of them silence.", sb.results_seen, sb.silent_seen);
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
